/* hw/rtl/slb_pkg.sv */
// Shared widths, register indexes and types for the seam linear blend.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package slb_pkg;

    // Field widths.
    localparam int unsigned PIX_W = 8;
    localparam int unsigned COL_W = 12;
    localparam int unsigned LW_W  = 13;

    // Largest blend numerator is 255 * 8191, which fits in 21 bits.
    localparam int unsigned NUM_W = PIX_W + LW_W;

    // One quotient bit is resolved per division step.
    localparam int unsigned DIV_STEPS = PIX_W;

    // Registers from input to the last division step inside the lanes.
    localparam int unsigned PIPE_LAT = 2 + DIV_STEPS;

    // Image width assumed after reset.
    localparam int unsigned MAX_COLUMNS = 4096;
    localparam logic [LW_W-1:0] LEFT_WIDTH_RST = LW_W'(MAX_COLUMNS);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_WIDTH    = 1'b1;

    // Number of colour channels, one lane each.
    localparam int unsigned NUM_LANES = 3;

    // Weights and divisor shared by all lanes for one request.
    typedef struct packed {
        logic [LW_W-1:0]  wa;
        logic [COL_W-1:0] wb;
        logic [LW_W-1:0]  div;
    } t_weights;

endpackage

`default_nettype wire

/* hw/rtl/slb_lane.sv */
// One colour channel lane: weighted sum followed by a pipelined restoring divider.
// Depends on slb_pkg.
`default_nettype none

module slb_lane (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [slb_pkg::PIX_W-1:0]   i_a,
    input  wire logic [slb_pkg::PIX_W-1:0]   i_b,
    input  wire slb_pkg::t_weights           i_wt,
    output logic      [slb_pkg::PIX_W-1:0]   o_q
);
    import slb_pkg::*;

    localparam int unsigned REM_W = NUM_W + 1;

    logic [NUM_W-1:0]       prod_a;
    logic [PIX_W+COL_W-1:0] prod_b;

    logic [NUM_W-1:0] r_num;
    logic [LW_W-1:0]  r_div0;

    logic [NUM_W-1:0] r_rem [1:DIV_STEPS-1];
    logic [LW_W-1:0]  r_w   [1:DIV_STEPS-1];
    logic [PIX_W-1:0] r_q   [1:DIV_STEPS];

    assign prod_a = i_a * i_wt.wa;
    assign prod_b = i_b * i_wt.wb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= prod_a + NUM_W'(prod_b);
            r_div0 <= i_wt.div;
        end
    end

    // Each step tries to subtract the divisor shifted to its quotient bit.
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic [NUM_W-1:0] rem_in;
        logic [LW_W-1:0]  w_in;
        logic [PIX_W-1:0] q_in;
        logic [REM_W-1:0] trial;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_in = r_num;
            assign w_in   = r_div0;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[s];
            assign w_in   = r_w[s];
            assign q_in   = r_q[s];
        end

        assign trial = {1'b0, rem_in} - (REM_W'(w_in) << (DIV_STEPS - 1 - s));
        assign take  = !trial[REM_W-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1] <= {q_in[PIX_W-2:0], take};
            end
        end

        if (s < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1] <= take ? trial[NUM_W-1:0] : rem_in;
                    r_w[s+1]   <= w_in;
                end
            end
        end
    end

    assign o_q = r_q[DIV_STEPS];

endmodule

`default_nettype wire

/* hw/rtl/seam_linear_blend.sv */
// Top level of the seam linear blend: configuration, request classification,
// three channel lanes and the output register. Depends on slb_pkg and slb_lane.
`default_nettype none

// The block blends a left image and a warped right image across a stitching
// overlap, one pixel per request. It accepts one request every clock cycle
// while the output is not stalled. Each result passes through the
// classification stage, the weighted-sum stage, the eight-step division
// pipeline in each of the three channel lanes and the output register. The
// whole pipeline advances together, so while a result waits in the output
// register under stall, new requests are held off as well. The
// classification stage folds the pass-through cases into the lanes: a
// left-image pixel is sent as the left value weighted by one over a divisor
// of one, and likewise for the right pixel, so every request takes the same
// path and order is kept by construction. Inside the overlap each channel is
// floor((left*(W-k) + right*k) / W), computed exactly. Configuration writes are
// always ready and take effect for the next request; they should be made only
// while no request is in flight.
module seam_linear_blend (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [slb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [slb_pkg::LW_W-1:0]        i_cfg_data,

    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [slb_pkg::COL_W-1:0]       i_column,
    input  wire logic [slb_pkg::PIX_W-1:0]       i_left_blue,
    input  wire logic [slb_pkg::PIX_W-1:0]       i_left_green,
    input  wire logic [slb_pkg::PIX_W-1:0]       i_left_red,
    input  wire logic [slb_pkg::PIX_W-1:0]       i_right_blue,
    input  wire logic [slb_pkg::PIX_W-1:0]       i_right_green,
    input  wire logic [slb_pkg::PIX_W-1:0]       i_right_red,

    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [slb_pkg::PIX_W-1:0]       o_out_blue,
    output logic      [slb_pkg::PIX_W-1:0]       o_out_green,
    output logic      [slb_pkg::PIX_W-1:0]       o_out_red
);
    import slb_pkg::*;

    // Configuration registers.
    logic [COL_W-1:0] r_overlap_start;
    logic [LW_W-1:0]  r_left_width;

    // Pipeline control.
    logic             adv;
    logic             r_vld [0:PIPE_LAT-1];
    logic             r_out_valid;

    // Classification of the incoming request.
    logic             go_right;
    logic             go_left;
    logic             right_black;
    logic [PIX_W-1:0] in_left  [0:NUM_LANES-1];
    logic [PIX_W-1:0] in_right [0:NUM_LANES-1];
    t_weights         n_wt;

    // Stage zero registers feeding the lanes.
    logic [PIX_W-1:0] r_a [0:NUM_LANES-1];
    logic [PIX_W-1:0] r_b [0:NUM_LANES-1];
    t_weights         r_wt;

    // Lane results and the output register.
    logic [PIX_W-1:0] lane_q [0:NUM_LANES-1];
    logic [PIX_W-1:0] r_out  [0:NUM_LANES-1];

    // The configuration port never needs to wait.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlap_start <= '0;
            r_left_width    <= LEFT_WIDTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OVERLAP_START: r_overlap_start <= i_cfg_data[COL_W-1:0];
                CFG_LEFT_WIDTH:    r_left_width    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Everything moves on unless a finished result is held by the sink.
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    assign in_left[0]  = i_left_blue;
    assign in_left[1]  = i_left_green;
    assign in_left[2]  = i_left_red;
    assign in_right[0] = i_right_blue;
    assign in_right[1] = i_right_green;
    assign in_right[2] = i_right_red;

    // Columns at or past the left width take the right pixel first; columns
    // before the overlap, or an all-black right pixel, take the left pixel.
    assign right_black = (i_right_blue == '0) && (i_right_green == '0)
                         && (i_right_red == '0);
    assign go_right    = {1'b0, i_column} >= r_left_width;
    assign go_left     = !go_right && ((i_column < r_overlap_start) || right_black);

    always_comb begin
        if (go_right) begin
            n_wt.wa  = '0;
            n_wt.wb  = COL_W'(1);
            n_wt.div = LW_W'(1);
        end else if (go_left) begin
            n_wt.wa  = LW_W'(1);
            n_wt.wb  = '0;
            n_wt.div = LW_W'(1);
        end else begin
            n_wt.wa  = r_left_width - {1'b0, i_column};
            n_wt.wb  = i_column - r_overlap_start;
            n_wt.div = r_left_width - {1'b0, r_overlap_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wt <= n_wt;
            for (int c = 0; c < NUM_LANES; c++) begin
                r_a[c] <= in_left[c];
                r_b[c] <= in_right[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s < PIPE_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_valid <= r_vld[PIPE_LAT-1];
        end
    end

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        slb_lane u_lane (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_a   (r_a[c]),
            .i_b   (r_b[c]),
            .i_wt  (r_wt),
            .o_q   (lane_q[c])
        );
    end

    // The lanes finish together; the output register gathers their results.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                r_out[c] <= lane_q[c];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_blue  = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_red   = r_out[2];

endmodule

`default_nettype wire

/* hw/rtl/slb_checker.sv */
// Port-level checks for the seam linear blend, bound to its top level.
// Depends on slb_pkg and on the ports of seam_linear_blend.
`default_nettype none

module slb_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            o_in_stall,
    input  wire logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    input  wire logic [slb_pkg::PIX_W-1:0]       o_out_blue,
    input  wire logic [slb_pkg::PIX_W-1:0]       o_out_green,
    input  wire logic [slb_pkg::PIX_W-1:0]       o_out_red
);

    // A result held by the sink stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // A held result keeps its pixel.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_out_blue) && $stable(o_out_green) && $stable(o_out_red))
        else $error("result changed while stalled");

    // Requests are only held off while a finished result waits at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("request stalled without back-pressure");

    // Reset leaves nothing in flight.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

endmodule

bind seam_linear_blend slb_checker u_slb_checker (.*);

`default_nettype wire
